// File: sv/j1939tr_pkg.sv
// types and constants shared by the transport reassembler
`default_nettype none
package j1939tr_pkg;
   localparam logic [17:0] GRP_TP_CM = 18'h0EC00;
   localparam logic [17:0] GRP_TP_DT = 18'h0EB00;
   localparam logic [7:0] CTL_BAM = 8'h20;
   localparam logic [7:0] CTL_RTS = 8'h10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT_OUT
   } state_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_DROP,
      ACT_OPEN,
      ACT_STORE,
      ACT_STORE_DONE
   } action_type;

   typedef struct packed {
      logic load;
      logic apply;
      logic out_load;
      logic chunk_next;
      logic free_slot;
   } ctrl_type;

   typedef struct packed {
      action_type action;
      logic chunk_last;
      logic out_busy;
   } stat_type;
endpackage
`default_nettype wire

// File: sv/j1939tr_ram.sv
// generic ram with one write port and one registered read port
`default_nettype none
module j1939tr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: sv/j1939tr_ctrl.sv
// controller state machine of the reassembler
`default_nettype none
module j1939tr_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_fire,
   input  wire j1939tr_pkg::stat_type stat,
   output logic                       req_ready,
   output j1939tr_pkg::ctrl_type      ctrl
);
   import j1939tr_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (stat.action == ACT_STORE_DONE) state_in = ST_EMIT_RD;
            else state_in = ST_IDLE;
         end
         ST_EMIT_RD: state_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT: if (!stat.out_busy) state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            if (stat.chunk_last) state_in = ST_IDLE;
            else state_in = ST_EMIT_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_fire;
         end
         ST_DECIDE: ctrl.apply = 1'b1;
         ST_EMIT_RD: ;
         ST_EMIT_WAIT: ctrl.out_load = !stat.out_busy;
         ST_EMIT_OUT: begin
            ctrl.chunk_next = 1'b1;
            ctrl.free_slot = stat.chunk_last;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// File: sv/j1939tr_dp.sv
// session table, packet store and output register of the reassembler
`default_nettype none
module j1939tr_dp #(
   parameter int SESSIONS = 4,
   parameter int MAX_PACKETS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire j1939tr_pkg::ctrl_type ctrl,
   output j1939tr_pkg::stat_type      stat,
   input  wire logic                  req_ext,
   input  wire logic [17:0]           req_grp,
   input  wire logic [7:0]            req_src,
   input  wire logic [7:0]            req_dst,
   input  wire logic [6:0]            req_len,
   input  wire logic [63:0]           req_pay,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [111:0]               rsp_tdata,
   output logic                       rsp_tlast
);
   import j1939tr_pkg::*;
   localparam int SW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
   localparam int PW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
   localparam int DEPTH = SESSIONS * MAX_PACKETS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [10:0] MAX_SIZE = 11'(7 * MAX_PACKETS);

   logic ext_ff; logic [17:0] grp_ff; logic [7:0] src_ff, dst_ff;
   logic [6:0] len_ff; logic [63:0] pay_ff;
   logic [SESSIONS-1:0] valid_ff;
   logic [7:0] ssrc_ff [SESSIONS];
   logic [7:0] sdst_ff [SESSIONS];
   logic [10:0] ssize_ff [SESSIONS];
   logic [7:0] spk_ff [SESSIONS];
   logic [7:0] srx_ff [SESSIONS];
   logic [23:0] sgrp_ff [SESSIONS];
   logic [31:0] sstamp_ff [SESSIONS];
   logic [31:0] cnt_ff;
   logic [SW-1:0] eslot_ff;
   logic [7:0] chunk_ff;
   logic out_v_ff; logic [107:0] out_d_ff; logic out_l_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         ext_ff <= req_ext; grp_ff <= req_grp; src_ff <= req_src;
         dst_ff <= req_dst; len_ff <= req_len; pay_ff <= req_pay;
      end
   end

   // lookup of the pair
   logic hit; logic [SW-1:0] hit_idx;
   always_comb begin
      hit = 1'b0; hit_idx = '0;
      for (int s = SESSIONS - 1; s >= 0; s--) begin
         if (valid_ff[s] && ssrc_ff[s] == src_ff && sdst_ff[s] == dst_ff) begin
            hit = 1'b1; hit_idx = SW'(s);
         end
      end
   end

   // victim: lowest free slot after the drop, else oldest stamp
   logic [SESSIONS-1:0] after_drop;
   logic any_free; logic [SW-1:0] free_idx, old_idx; logic [31:0] old_st;
   always_comb begin
      after_drop = valid_ff;
      if (hit) after_drop[hit_idx] = 1'b0;
      any_free = 1'b0; free_idx = '0;
      for (int s = SESSIONS - 1; s >= 0; s--) begin
         if (!after_drop[s]) begin
            any_free = 1'b1; free_idx = SW'(s);
         end
      end
      old_idx = '0; old_st = sstamp_ff[0];
      for (int s = 1; s < SESSIONS; s++) begin
         if (sstamp_ff[s] < old_st) begin
            old_st = sstamp_ff[s]; old_idx = SW'(s);
         end
      end
   end

   // packet count must equal the size rounded up to whole packets
   logic [10:0] size; logic [7:0] pk; logic [10:0] pk7; logic pk_fit;
   logic [7:0] rx; logic [8:0] rx1;
   always_comb begin
      size = {pay_ff[23:16], pay_ff[15:8]} > 16'(MAX_SIZE) ? 11'h7ff
           : 11'({pay_ff[23:16], pay_ff[15:8]});
      pk = pay_ff[31:24];
      pk7 = {pk, 3'b000} - 11'(pk);
      pk_fit = (12'(size) + 12'd6 >= 12'(pk7)) && (size <= pk7);
      rx = srx_ff[hit_idx];
      rx1 = 9'(rx) + 9'd1;
   end

   logic cm_ok, bad;
   action_type action;
   always_comb begin
      cm_ok = (pay_ff[7:0] == CTL_BAM || pay_ff[7:0] == CTL_RTS);
      bad = ({pay_ff[23:16], pay_ff[15:8]} == 16'd0)
         || ({pay_ff[23:16], pay_ff[15:8]} > 16'(MAX_SIZE))
         || pk == 8'd0 || !pk_fit;
      action = ACT_NONE;
      priority if (!ext_ff) action = ACT_NONE;
      else if (grp_ff == GRP_TP_CM) begin
         if (len_ff >= 7'd8 && cm_ok) action = bad ? ACT_DROP : ACT_OPEN;
      end else if (grp_ff == GRP_TP_DT && hit) begin
         if (len_ff < 7'd8 || pay_ff[7:0] != rx1[7:0] || 9'(rx) >= 9'(MAX_PACKETS))
            action = ACT_DROP;
         else if (rx1[7:0] >= spk_ff[hit_idx]) action = ACT_STORE_DONE;
         else action = ACT_STORE;
      end
   end

   logic [SW-1:0] new_idx;
   assign new_idx = any_free ? free_idx : old_idx;

   logic [SESSIONS-1:0] valid_in;
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.apply) begin
         if (action == ACT_DROP && hit) valid_in[hit_idx] = 1'b0;
         if (action == ACT_OPEN) begin
            valid_in = after_drop;
            valid_in[new_idx] = 1'b1;
         end
      end
      if (ctrl.free_slot) valid_in[eslot_ff] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0; cnt_ff <= '0;
         for (int s = 0; s < SESSIONS; s++) begin
            ssrc_ff[s] <= '0; sdst_ff[s] <= '0; ssize_ff[s] <= '0; spk_ff[s] <= '0;
            srx_ff[s] <= '0; sgrp_ff[s] <= '0; sstamp_ff[s] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         if (ctrl.apply) begin
            unique case (action)
               ACT_NONE: ;
               ACT_DROP: ;
               ACT_OPEN: begin
                  ssrc_ff[new_idx] <= src_ff; sdst_ff[new_idx] <= dst_ff;
                  ssize_ff[new_idx] <= size; spk_ff[new_idx] <= pk;
                  srx_ff[new_idx] <= '0;
                  sgrp_ff[new_idx] <= pay_ff[63:40];
                  sstamp_ff[new_idx] <= cnt_ff;
                  cnt_ff <= cnt_ff + 32'd1;
               end
               ACT_STORE, ACT_STORE_DONE: srx_ff[hit_idx] <= rx1[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.apply) begin
         eslot_ff <= hit_idx; chunk_ff <= '0;
      end else if (ctrl.chunk_next) chunk_ff <= chunk_ff + 8'd1;
   end

   // packet store
   logic wr_en; logic [AW-1:0] wr_addr, rd_addr; logic [55:0] rd_data;
   assign wr_en = ctrl.apply && (action == ACT_STORE || action == ACT_STORE_DONE);
   assign wr_addr = AW'(32'(hit_idx) * MAX_PACKETS + 32'(rx[PW-1:0]));
   assign rd_addr = AW'(32'(eslot_ff) * MAX_PACKETS + 32'(chunk_ff[PW-1:0]));
   j1939tr_ram #(.WIDTH(56), .DEPTH(DEPTH)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(pay_ff[63:8]),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // chunk shaping
   logic [10:0] esize, done_bytes, remain; logic [2:0] vb; logic lastc;
   logic [55:0] mask;
   always_comb begin
      esize = ssize_ff[eslot_ff];
      done_bytes = 11'(chunk_ff) * 11'd7;
      remain = esize - done_bytes;
      lastc = remain <= 11'd7;
      vb = lastc ? remain[2:0] : 3'd7;
      mask = '0;
      for (int b = 0; b < 7; b++) if (3'(b) < vb) mask[8*b +: 8] = 8'hff;
   end

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (ctrl.out_load) out_v_ff <= 1'b1;
      else if (rsp_tready) out_v_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         out_d_ff <= {vb, rd_data & mask, esize[8:0], sdst_ff[eslot_ff],
                      ssrc_ff[eslot_ff], sgrp_ff[eslot_ff]};
         out_l_ff <= lastc;
      end
   end

   assign stat.action = action;
   assign stat.chunk_last = out_l_ff;
   assign stat.out_busy = out_v_ff && !rsp_tready;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {4'b0, out_d_ff};
   assign rsp_tlast = out_l_ff;
endmodule
`default_nettype wire

// File: sv/j1939_transport_reassembler_unit.sv
// top level of the j1939 transport reassembler
`default_nettype none
// Reassembles BAM/RTS transport sessions from decoded extended CAN frames.
// Frames are accepted in ST_IDLE and applied to SESSIONS registered slots in
// ST_DECIDE; a completing data frame then emits chunks of up to 7 bytes, each
// via ST_EMIT_RD, ST_EMIT_WAIT, ST_EMIT_OUT and the registered store read,
// and any result-side stall. No new request is taken while a message drains.
module j1939_transport_reassembler_unit #(
   parameter int SESSIONS = 4,
   parameter int MAX_PACKETS = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // extended_id, group_number, source_addr, dest_addr, payload_len, payload_bytes
   input  wire logic [111:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // msg_group, msg_source, msg_dest, msg_length, chunk_data, chunk_valid_bytes
   output logic [111:0]      rsp_tdata,
   output logic              rsp_tlast
);
   import j1939tr_pkg::*;
   ctrl_type ctrl;
   stat_type stat;
   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   j1939tr_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .stat(stat),
      .req_ready(req_tready), .ctrl(ctrl)
   );

   j1939tr_dp #(.SESSIONS(SESSIONS), .MAX_PACKETS(MAX_PACKETS)) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_ext(req_tdata[0]), .req_grp(req_tdata[18:1]), .req_src(req_tdata[26:19]),
      .req_dst(req_tdata[34:27]), .req_len(req_tdata[41:35]),
      .req_pay(req_tdata[105:42]),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

`ifndef SYNTHESIS
   a_no_load_while_out: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |-> !(rsp_tvalid && !rsp_tready)) else $error("chunk overwritten");
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready) else $error("request taken while busy");
   a_bytes_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[107:105] != 3'd0) else $error("empty chunk");
`endif
endmodule
`default_nettype wire

// File: sim/j1939_transport_reassembler_unit_test.sv
// self-checking testbench for the j1939 transport reassembler
module j1939_transport_reassembler_unit_test;
   import j1939tr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SESSIONS = 4;
   localparam int MAX_PACKETS = 64;
   localparam int IDLE_LIMIT = 6000;

   typedef struct packed {
      logic [2:0]  valid_bytes;
      logic [55:0] data;
      logic [8:0]  length;
      logic [7:0]  dest;
      logic [7:0]  source;
      logic [23:0] group;
   } chunk_type;

   typedef struct {
      chunk_type  body;
      logic       last;
   } expected_chunk_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   logic         rsp_tlast;

   j1939_transport_reassembler_unit #(
      .SESSIONS(SESSIONS),
      .MAX_PACKETS(MAX_PACKETS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // session table copy
   logic        sess_valid [SESSIONS];
   logic [7:0]  sess_source [SESSIONS];
   logic [7:0]  sess_dest [SESSIONS];
   logic [10:0] sess_size [SESSIONS];
   logic [7:0]  sess_packets [SESSIONS];
   logic [7:0]  sess_received [SESSIONS];
   logic [23:0] sess_group [SESSIONS];
   logic [31:0] sess_stamp [SESSIONS];
   logic [31:0] opened_count = '0;
   logic [55:0] packet_data [SESSIONS*MAX_PACKETS];

   expected_chunk_type pending_chunks[$];
   int mismatches = 0;
   int frames_sent = 0;
   int idle_cycles = 0;
   int hold_cycles = 0;
   bit sender_quiet = 1'b0;
   bit receiver_quiet = 1'b0;

   function automatic int find_session(logic [7:0] src, logic [7:0] dst);
      for (int s = 0; s < SESSIONS; s++)
         if (sess_valid[s] && sess_source[s] == src && sess_dest[s] == dst) return s;
      return -1;
   endfunction

   function automatic void reassemble_frame(logic ext, logic [17:0] grp, logic [7:0] src,
                                            logic [7:0] dst, logic [6:0] len,
                                            logic [63:0] pay);
      int s;
      int pick;
      int size;
      int pk;
      int n;
      int vb;
      expected_chunk_type e;
      if (!ext) return;
      if (grp == GRP_TP_CM) begin
         if (len < 8) return;
         if (pay[7:0] != CTL_BAM && pay[7:0] != CTL_RTS) return;
         size = pay[23:8];
         pk = pay[31:24];
         s = find_session(src, dst);
         if (s >= 0) sess_valid[s] = 1'b0;
         if (size == 0 || size > 7 * MAX_PACKETS || pk == 0 || pk != (size + 6) / 7) return;
         pick = -1;
         for (int i = 0; i < SESSIONS; i++)
            if (pick < 0 && !sess_valid[i]) pick = i;
         if (pick < 0) begin
            pick = 0;
            for (int i = 1; i < SESSIONS; i++)
               if (sess_stamp[i] < sess_stamp[pick]) pick = i;
         end
         sess_valid[pick] = 1'b1;
         sess_source[pick] = src;
         sess_dest[pick] = dst;
         sess_size[pick] = 11'(size);
         sess_packets[pick] = 8'(pk);
         sess_received[pick] = '0;
         sess_group[pick] = pay[63:40];
         sess_stamp[pick] = opened_count;
         opened_count++;
      end else if (grp == GRP_TP_DT) begin
         s = find_session(src, dst);
         if (s < 0) return;
         if (len < 8 || pay[7:0] != sess_received[s] + 8'd1 || sess_received[s] >= MAX_PACKETS)
         begin
            sess_valid[s] = 1'b0;
            return;
         end
         packet_data[s * MAX_PACKETS + sess_received[s]] = pay[63:8];
         sess_received[s]++;
         if (sess_received[s] < sess_packets[s]) return;
         size = sess_size[s];
         n = (size + 6) / 7;
         for (int k = 0; k < n; k++) begin
            vb = (k + 1 == n) ? size - 7 * k : 7;
            e.body.data = packet_data[s * MAX_PACKETS + k];
            for (int b = vb; b < 7; b++) e.body.data[8*b +: 8] = 8'h00;
            e.body.group = sess_group[s];
            e.body.source = src;
            e.body.dest = dst;
            e.body.length = 9'(size);
            e.body.valid_bytes = 3'(vb);
            e.last = (k + 1 == n);
            pending_chunks.insert(pending_chunks.size(), e);
         end
         sess_valid[s] = 1'b0;
      end
   endfunction

   task automatic send_frame(logic ext, logic [17:0] grp, logic [7:0] src, logic [7:0] dst,
                             logic [6:0] len, logic [63:0] pay);
      while (!sender_quiet && $urandom_range(0, 99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, pay, len, dst, src, grp, ext};
      do @(posedge clock); while (!req_tready);
      reassemble_frame(ext, grp, src, dst, len, pay);
      frames_sent++;
   endtask

   task automatic send_announce(logic [7:0] ctl, logic [7:0] src, logic [7:0] dst,
                                int size, int pk, logic [23:0] grp);
      send_frame(1'b1, GRP_TP_CM, src, dst, 7'd8,
                 {grp, 8'($urandom), 8'(pk), 16'(size), ctl});
   endtask

   task automatic send_packet(logic [7:0] src, logic [7:0] dst, logic [7:0] seq,
                              logic [6:0] len);
      send_frame(1'b1, GRP_TP_DT, src, dst, len, {$urandom, 24'($urandom), seq});
   endtask

   task automatic send_noise();
      logic [17:0] grp;
      grp = 18'($urandom);
      case ($urandom_range(0, 2))
         0: send_frame(1'b0, GRP_TP_DT, 8'($urandom), 8'($urandom), 7'd8,
                       {$urandom, $urandom});
         1: send_frame(1'b1, grp, 8'($urandom), 8'($urandom), 7'($urandom_range(0, 64)),
                       {$urandom, $urandom});
         default: send_frame(1'b1, GRP_TP_CM, 8'($urandom), 8'($urandom),
                             7'($urandom_range(0, 64)), {$urandom, $urandom});
      endcase
   endtask

   // one message with random content, sometimes broken or interleaved with noise
   task automatic send_message(logic [7:0] src, logic [7:0] dst, int size, bit broken);
      int pk;
      int bad_at;
      pk = (size + 6) / 7;
      bad_at = broken ? $urandom_range(1, pk) : 0;
      send_announce($urandom_range(0, 1) ? CTL_BAM : CTL_RTS, src, dst, size, pk,
                    24'($urandom));
      for (int p = 1; p <= pk; p++) begin
         if ($urandom_range(0, 99) < 8) send_noise();
         if (p == bad_at) begin
            if ($urandom_range(0, 1)) send_packet(src, dst, 8'(p + $urandom_range(1, 254)), 7'd8);
            else send_packet(src, dst, 8'(p), 7'($urandom_range(0, 7)));
         end else begin
            send_packet(src, dst, 8'(p), $urandom_range(0, 3) == 0 ?
                        7'($urandom_range(9, 64)) : 7'd8);
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_chunks.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic test_ignored_frames();
      send_frame(1'b0, GRP_TP_CM, 8'h01, 8'h02, 7'd8, {24'h0, 8'h0, 8'd1, 16'd5, CTL_BAM});
      send_frame(1'b1, 18'h3FFFF, 8'hFF, 8'hFF, 7'd64, '1);
      send_frame(1'b1, GRP_TP_CM, 8'h01, 8'h02, 7'd7, {24'h0, 8'h0, 8'd1, 16'd5, CTL_RTS});
      send_frame(1'b1, GRP_TP_CM, 8'h01, 8'h02, 7'd8, {24'h0, 8'h0, 8'd1, 16'd5, 8'h11});
      send_packet(8'h01, 8'h02, 8'd1, 7'd8);
   endtask

   task automatic test_bad_announce();
      send_announce(CTL_BAM, 8'h00, 8'h00, 0, 0, 24'h1);
      send_announce(CTL_BAM, 8'h00, 8'h00, 7 * MAX_PACKETS + 1, MAX_PACKETS + 1, 24'h1);
      send_announce(CTL_RTS, 8'h00, 8'h00, 5, 0, 24'h1);
      send_announce(CTL_RTS, 8'h00, 8'h00, 15, 2, 24'h1);
      send_packet(8'h00, 8'h00, 8'd1, 7'd8);
   endtask

   task automatic test_short_messages();
      send_announce(CTL_BAM, 8'h00, 8'hFF, 1, 1, 24'hFFFFFF);
      send_packet(8'h00, 8'hFF, 8'd1, 7'd64);
      send_announce(CTL_RTS, 8'hFF, 8'h00, 14, 2, 24'h000000);
      send_packet(8'hFF, 8'h00, 8'd1, 7'd8);
      send_packet(8'hFF, 8'h00, 8'd3, 7'd8);
      send_packet(8'hFF, 8'h00, 8'd2, 7'd8);
      send_announce(CTL_RTS, 8'h10, 8'h20, 8, 2, 24'h123456);
      send_packet(8'h10, 8'h20, 8'd1, 7'd3);
      send_packet(8'h10, 8'h20, 8'd2, 7'd8);
      wait_drained();
   endtask

   task automatic test_full_table();
      for (int i = 0; i < SESSIONS + 2; i++)
         send_announce(CTL_BAM, 8'(8'h40 + i), 8'h01, 9, 2, 24'(i));
      for (int i = 0; i < SESSIONS + 2; i++) begin
         send_packet(8'(8'h40 + i), 8'h01, 8'd1, 7'd8);
         send_packet(8'(8'h40 + i), 8'h01, 8'd2, 7'd8);
      end
      wait_drained();
   endtask

   task automatic test_largest_message();
      send_message(8'hA5, 8'h5A, 7 * MAX_PACKETS, 1'b0);
      wait_drained();
   endtask

   task automatic test_result_backpressure();
      hold_cycles = 400;
      sender_quiet = 1'b1;
      send_message(8'h33, 8'h44, 40, 1'b0);
      send_message(8'h34, 8'h44, 20, 1'b0);
      send_message(8'h35, 8'h44, 3, 1'b0);
      sender_quiet = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_sessions();
      logic [7:0] src;
      logic [7:0] dst;
      int size;
      while (frames_sent < 230) begin
         if (frames_sent > 150 && frames_sent < 195) begin
            sender_quiet = 1'b1;
            receiver_quiet = 1'b1;
         end else begin
            sender_quiet = 1'b0;
            receiver_quiet = 1'b0;
         end
         src = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2));
         dst = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2));
         size = $urandom_range(0, 19) == 0 ? $urandom_range(1, 7 * MAX_PACKETS)
                                           : $urandom_range(1, 30);
         case ($urandom_range(0, 9))
            0: send_noise();
            1: send_announce(8'($urandom), src, dst, $urandom_range(0, 500), 8'($urandom),
                             24'($urandom));
            2: send_message(src, dst, size, 1'b1);
            default: send_message(src, dst, size, 1'b0);
         endcase
      end
      sender_quiet = 1'b0;
      receiver_quiet = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_chunks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected chunk: data %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            automatic expected_chunk_type e = pending_chunks.pop_front();
            automatic logic [111:0] packed_exp = {4'b0, e.body};
            if (rsp_tdata !== packed_exp || rsp_tlast !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("chunk mismatch: expected %h last %b, got %h last %b",
                           packed_exp, e.last, rsp_tdata, rsp_tlast);
            end
         end
      end
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= receiver_quiet || $urandom_range(0, 99) >= 27;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_cycles > 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      for (int s = 0; s < SESSIONS; s++) begin
         sess_valid[s] = 1'b0;
         sess_stamp[s] = '0;
         sess_received[s] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_ignored_frames();
      test_bad_announce();
      test_short_messages();
      test_full_table();
      test_largest_message();
      test_result_backpressure();
      test_random_sessions();
      wait_drained();
      if (mismatches == 0 && pending_chunks.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

// File: filelist.f
sv/j1939tr_pkg.sv
sv/j1939tr_ram.sv
sv/j1939tr_ctrl.sv
sv/j1939tr_dp.sv
sv/j1939_transport_reassembler_unit.sv
sim/j1939_transport_reassembler_unit_test.sv
